>>> src/assert_macros.svh
// Assertion macros for the RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds whenever trig holds.
`define AST_IMPL(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// Check that cond holds in the cycle after trig.
`define AST_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

>>> src/i2p_pkg.sv
// Types and codes for the shunting-yard postfix converter.
// Depends on nothing; used by i2p_cell and the top level.
package i2p_pkg;

    // Token categories
    localparam logic [2:0] OP_OPERAND = 3'd0;
    localparam logic [2:0] OP_OPERATOR = 3'd1;
    localparam logic [2:0] OP_LPAREN = 3'd2;
    localparam logic [2:0] OP_RPAREN = 3'd3;
    localparam logic [2:0] OP_END = 3'd4;

    // Status codes
    localparam logic [1:0] STS_OK = 2'd0;
    localparam logic [1:0] STS_MISS_RPAREN = 2'd1;
    localparam logic [1:0] STS_MISS_LPAREN = 2'd2;
    localparam logic [1:0] STS_OVERFLOW = 2'd3;

    // One stack entry
    typedef struct packed {
        logic       lparen;
        logic [2:0] prec;
        logic [7:0] code;
    } t_entry;

    // Stack shift control, broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

endpackage

>>> src/infix_to_postfix_converter_core.sv
// Top level of the shunting-yard infix to postfix converter.
// Depends on i2p_pkg, i2p_cell and assert_macros.svh.
//
// Channel | valid      | ready       | payload
// input   | i_in_valid | o_in_ready  | i_op, i_token_code, i_precedence
// output  | o_out_valid| i_out_ready | o_has_token .. o_last
//
// One token is taken while idle, then worked one step at a time in a busy phase.
// An operand is emitted in one step; an operator pops and emits entries, then
// pushes itself; a right paren or end item pops one entry per step. The stack
// is a row of shifting cells, at most one pop or push per cycle. Steps that emit
// wait for the output register; reset clears control state and empties the stack.
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_op,
    input  logic [7:0] i_token_code,
    input  logic [2:0] i_precedence,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_has_token,
    output logic [7:0] o_token_code_res,
    output logic [2:0] o_precedence_res,
    output logic       o_token_is_lparen,
    output logic [1:0] o_status,
    output logic       o_last
);
    import i2p_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_err, n_err;
    logic [2:0]    r_op;
    logic [7:0]    r_code;
    logic [2:0]    r_prec;

    logic          r_out_valid, n_out_valid;
    logic          r_has, r_lp, r_last;
    logic [7:0]    r_ocode;
    logic [2:0]    r_oprec;
    logic [1:0]    r_ost;

    t_stk_ctl      w_ctl;
    t_entry        w_new;
    t_entry        w_cell [STACK_DEPTH];
    t_entry        w_top, w_nxt;
    logic          w_out_free;
    logic          w_emit, w_step_emit, w_emit_stat;
    logic          w_e_has, w_e_lp, w_e_last;
    logic [7:0]    w_e_code;
    logic [2:0]    w_e_prec;
    logic [1:0]    w_e_st;
    logic          w_done, w_full, w_empty;

    assign w_top      = w_cell[0];
    assign w_nxt      = w_cell[1];
    assign w_full     = (r_cnt == CW'(STACK_DEPTH));
    assign w_empty    = (r_cnt == '0);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_new      = '{lparen: (r_op == OP_LPAREN), prec: r_prec, code: r_code};

    // Row of stack cells; cell 0 is the top
    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        t_entry w_up, w_down;
        t_entry w_entry_k;
        if (k == 0) begin : g_first
            assign w_up = w_new;
        end else begin : g_mid
            assign w_up = w_cell[k-1];
        end
        if (k == STACK_DEPTH - 1) begin : g_last
            assign w_down = w_cell[k];
        end else begin : g_inner
            assign w_down = w_cell[k+1];
        end
        i2p_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_entry     (w_entry_k)
        );
        assign w_cell[k] = w_entry_k;
    end

    // Decide one step of the current token
    always_comb begin
        w_step_emit = 1'b0;
        w_emit_stat = 1'b0;
        w_e_has     = 1'b1;
        w_e_code    = w_top.code;
        w_e_prec    = w_top.prec;
        w_e_lp      = w_top.lparen;
        w_e_st      = STS_OK;
        w_e_last    = 1'b0;
        w_done      = 1'b0;
        w_ctl       = '0;
        n_err       = r_err;
        case (r_op)
            OP_OPERAND: begin
                w_step_emit = 1'b1;
                w_e_code    = r_code;
                w_e_prec    = r_prec;
                w_e_lp      = 1'b0;
                w_e_last    = 1'b1;
                w_done      = 1'b1;
            end
            OP_OPERATOR: begin
                if (!w_empty && !w_top.lparen && (r_prec <= w_top.prec)) begin
                    w_step_emit = 1'b1;
                    w_ctl.pop   = 1'b1;
                    w_e_last    = !((r_cnt > CW'(1)) && !w_nxt.lparen &&
                                    (r_prec <= w_nxt.prec));
                end else begin
                    w_done = 1'b1;
                    if (w_full) begin
                        n_err = STS_OVERFLOW;
                    end else begin
                        w_ctl.push = 1'b1;
                    end
                end
            end
            OP_LPAREN: begin
                w_done = 1'b1;
                if (w_full) begin
                    n_err = STS_OVERFLOW;
                end else begin
                    w_ctl.push = 1'b1;
                end
            end
            OP_RPAREN: begin
                if (w_empty) begin
                    n_err  = STS_MISS_LPAREN;
                    w_done = 1'b1;
                end else if (w_top.lparen) begin
                    w_ctl.pop = 1'b1;
                    w_done    = 1'b1;
                end else begin
                    w_step_emit = 1'b1;
                    w_ctl.pop   = 1'b1;
                    w_e_last    = (r_cnt == CW'(1)) || w_nxt.lparen;
                end
            end
            OP_END: begin
                if (!w_empty) begin
                    w_step_emit = 1'b1;
                    w_ctl.pop   = 1'b1;
                    if (w_top.lparen) begin
                        n_err = STS_MISS_RPAREN;
                    end
                end else begin
                    w_step_emit = 1'b1;
                    w_emit_stat = 1'b1;
                    w_e_has     = 1'b0;
                    w_e_code    = '0;
                    w_e_prec    = '0;
                    w_e_lp      = 1'b0;
                    w_e_st      = r_err;
                    w_e_last    = 1'b1;
                    w_done      = 1'b1;
                    n_err       = STS_OK;
                end
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
        // Hold the whole step while idle or while an emitting step finds the output full
        if ((r_state != S_BUSY) || (w_step_emit && !w_out_free)) begin
            w_ctl       = '0;
            n_err       = r_err;
            w_done      = 1'b0;
            w_step_emit = 1'b0;
            w_emit_stat = 1'b0;
        end
    end

    assign w_emit = w_step_emit;

    // Next state, count and output valid
    always_comb begin
        n_state = r_state;
        if (r_state == S_IDLE && i_in_valid) begin
            n_state = S_BUSY;
        end else if (w_done) begin
            n_state = S_IDLE;
        end
        n_cnt = r_cnt;
        if (w_ctl.push) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_ctl.pop) begin
            n_cnt = r_cnt - CW'(1);
        end
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_err       <= STS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Latch the request and load the result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op   <= i_op;
            r_code <= i_token_code;
            r_prec <= i_precedence;
        end
        if (w_emit) begin
            r_has   <= w_e_has;
            r_ocode <= w_e_code;
            r_oprec <= w_e_prec;
            r_lp    <= w_e_lp;
            r_ost   <= w_e_st;
            r_last  <= w_e_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_has_token       = r_has;
    assign o_token_code_res  = r_ocode;
    assign o_precedence_res  = r_oprec;
    assign o_token_is_lparen = r_lp;
    assign o_status          = r_ost;
    assign o_last            = r_last;

    `AST_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(STACK_DEPTH))
    `AST_IMPL(a_pop_nonempty, i_clk, i_rst_n, w_ctl.pop, !w_empty)
    `AST_IMPL(a_stat_last, i_clk, i_rst_n, r_out_valid && !r_has, r_last)
    `AST_NEXT(a_err_clear, i_clk, i_rst_n, w_emit_stat, r_err == STS_OK)

endmodule

>>> src/i2p_cell.sv
// One cell of the shifting operator stack.
// Depends on i2p_pkg.
module i2p_cell (
    input  logic              i_clk,
    input  i2p_pkg::t_stk_ctl i_ctl,
    input  i2p_pkg::t_entry   i_from_up,
    input  i2p_pkg::t_entry   i_from_down,
    output i2p_pkg::t_entry   o_entry
);
    import i2p_pkg::*;

    t_entry r_entry;

    // Shift toward the bottom on push, toward the top on pop
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_from_up;
        end else if (i_ctl.pop) begin
            r_entry <= i_from_down;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the shunting-yard infix to postfix converter.
// Depends on i2p_pkg and infix_to_postfix_converter_core; predicts every postfix
// result in SystemVerilog and checks it in order, under random idle and stall.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2p_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam int RANDOM_ITEMS = 150;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 250;
    localparam int MAX_REPORTS = 10;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // Categories the block ignores
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // One postfix result as it leaves the block
    typedef struct packed {
        logic       has_token;
        logic [7:0] code;
        logic [2:0] prec;
        logic       lparen;
        logic [1:0] status;
        logic       last;
    } t_postfix;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [2:0] i_op = OP_OPERAND;
    logic [7:0] i_token_code = 8'd0;
    logic [2:0] i_precedence = 3'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_has_token;
    logic [7:0] o_token_code_res;
    logic [2:0] o_precedence_res;
    logic       o_token_is_lparen;
    logic [1:0] o_status;
    logic       o_last;

    // Predictor state: operator stack, its depth and the sticky status
    t_entry     op_stack_m [STACK_DEPTH];
    int         stack_depth_m = 0;
    logic [1:0] sticky_status = STS_OK;
    t_postfix   expected_q [$];

    int   mismatches = 0;
    int   tokens_accepted = 0;
    logic no_idle = 1'b0;
    logic rx_hold = 1'b0;

    infix_to_postfix_converter_core #(.STACK_DEPTH(STACK_DEPTH)) dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic t_postfix token_out(t_entry e);
        return '{1'b1, e.code, e.prec, e.lparen, STS_OK, 1'b0};
    endfunction

    // Push onto the model stack; drop the push and flag overflow when full
    function automatic void push_entry(t_entry e);
        if (stack_depth_m >= STACK_DEPTH) begin
            sticky_status = STS_OVERFLOW;
        end else begin
            op_stack_m[stack_depth_m] = e;
            stack_depth_m++;
        end
    endfunction

    // Work out the postfix results of one accepted token and queue them
    function automatic void predict_postfix(logic [2:0] op, logic [7:0] code,
                                            logic [2:0] prec);
        t_postfix batch [$];
        t_entry   top;
        logic     matched;
        matched = 1'b0;
        case (op)
            OP_OPERAND: begin
                batch.push_back(token_out('{1'b0, prec, code}));
            end
            OP_OPERATOR: begin
                // pop while the top is an operator of equal or higher precedence
                while (stack_depth_m > 0 && !op_stack_m[stack_depth_m - 1].lparen &&
                       prec <= op_stack_m[stack_depth_m - 1].prec) begin
                    stack_depth_m--;
                    batch.push_back(token_out(op_stack_m[stack_depth_m]));
                end
                push_entry('{1'b0, prec, code});
            end
            OP_LPAREN: begin
                push_entry('{1'b1, prec, code});
            end
            OP_RPAREN: begin
                while (stack_depth_m > 0 && !matched) begin
                    stack_depth_m--;
                    top = op_stack_m[stack_depth_m];
                    if (top.lparen) begin
                        matched = 1'b1;
                    end else begin
                        batch.push_back(token_out(top));
                    end
                end
                if (!matched) begin
                    sticky_status = STS_MISS_LPAREN;
                end
            end
            OP_END: begin
                // flush everything, unmatched left parens included
                while (stack_depth_m > 0) begin
                    stack_depth_m--;
                    top = op_stack_m[stack_depth_m];
                    if (top.lparen) begin
                        sticky_status = STS_MISS_RPAREN;
                    end
                    batch.push_back(token_out(top));
                end
                batch.push_back('{1'b0, 8'd0, 3'd0, 1'b0, sticky_status, 1'b0});
                sticky_status = STS_OK;
            end
            default: ;
        endcase
        if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[k]) begin
            expected_q.push_back(batch[k]);
        end
    endfunction

    // Compare one accepted result with the oldest expectation
    task automatic check_result();
        t_postfix got;
        t_postfix want;
        got = '{o_has_token, o_token_code_res, o_precedence_res, o_token_is_lparen,
                o_status, o_last};
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: unexpected result tok=%0b code=%0d prec=%0d lp=%0b st=%0d last=%0b",
                         $realtime, got.has_token, got.code, got.prec, got.lparen,
                         got.status, got.last);
            end
        end else begin
            want = expected_q.pop_front();
            if (got.has_token !== want.has_token || got.code !== want.code ||
                got.prec !== want.prec || got.lparen !== want.lparen ||
                got.status !== want.status || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result differs: expected tok=%0b code=%0d prec=%0d lp=%0b st=%0d last=%0b",
                             $realtime, want.has_token, want.code, want.prec, want.lparen,
                             want.status, want.last);
                    $display("%0t:                  actual tok=%0b code=%0d prec=%0d lp=%0b st=%0d last=%0b",
                             $realtime, got.has_token, got.code, got.prec, got.lparen,
                             got.status, got.last);
                end
            end
        end
    endtask

    // Receiver: check each result and stall at random unless no_idle is set; rx_hold holds ready low
    always @(posedge i_clk) begin : receiver
        int unsigned stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall = 0;
        end else if (o_out_valid && i_out_ready) begin
            check_result();
            stall = no_idle ? 0 : $urandom_range(0, 3);
            i_out_ready <= (stall == 0) && !rx_hold;
        end else if (rx_hold) begin
            i_out_ready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            i_out_ready <= (stall == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Offer one request after a random gap and hold it until accepted
    task automatic send_token(logic [2:0] op, logic [7:0] code, logic [2:0] prec);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_token_code <= code;
        i_precedence <= prec;
        do @(posedge i_clk); while (!o_in_ready);
        predict_postfix(op, code, prec);
        if (op <= OP_END) begin
            tokens_accepted++;
        end
    endtask

    task automatic send_random(logic [2:0] op);
        send_token(op, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    endtask

    // Wait at least one edge, then until every expected result has come
    task automatic wait_results_done();
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    task automatic test_operands_and_end();
        send_token(OP_END, 8'd0, 3'd0);
        send_token(OP_OPERAND, 8'd0, 3'd0);
        send_token(OP_OPERAND, 8'd255, 3'd7);
        send_token(OP_END, 8'd255, 3'd7);
    endtask

    // a + b * c - d, then operators at the precedence extremes
    task automatic test_precedence_order();
        send_token(OP_OPERAND, 8'd1, 3'd0);
        send_token(OP_OPERATOR, 8'd10, 3'd3);
        send_token(OP_OPERAND, 8'd2, 3'd0);
        send_token(OP_OPERATOR, 8'd11, 3'd5);
        send_token(OP_OPERAND, 8'd3, 3'd0);
        send_token(OP_OPERATOR, 8'd12, 3'd3);
        send_token(OP_OPERAND, 8'd4, 3'd0);
        send_token(OP_OPERATOR, 8'd255, 3'd7);
        send_token(OP_OPERAND, 8'd5, 3'd7);
        send_token(OP_OPERATOR, 8'd0, 3'd0);
        send_token(OP_OPERAND, 8'd6, 3'd0);
        send_token(OP_END, 8'd0, 3'd0);
    endtask

    // Nested parens, and an operator stopping at a high-precedence paren
    task automatic test_paren_matching();
        send_token(OP_LPAREN, 8'd40, 3'd0);
        send_token(OP_OPERAND, 8'd1, 3'd0);
        send_token(OP_OPERATOR, 8'd10, 3'd4);
        send_token(OP_LPAREN, 8'd40, 3'd0);
        send_token(OP_OPERAND, 8'd2, 3'd0);
        send_token(OP_OPERATOR, 8'd11, 3'd6);
        send_token(OP_OPERAND, 8'd3, 3'd0);
        send_token(OP_RPAREN, 8'd41, 3'd0);
        send_token(OP_RPAREN, 8'd41, 3'd0);
        send_token(OP_OPERATOR, 8'd12, 3'd4);
        send_token(OP_LPAREN, 8'd255, 3'd7);
        send_token(OP_OPERAND, 8'd4, 3'd0);
        send_token(OP_OPERATOR, 8'd13, 3'd0);
        send_token(OP_OPERAND, 8'd5, 3'd0);
        send_token(OP_RPAREN, 8'd255, 3'd7);
        send_token(OP_END, 8'd0, 3'd0);
    endtask

    // Unmatched parens on either side, and a later error overwriting an earlier one
    task automatic test_paren_errors();
        send_token(OP_RPAREN, 8'd41, 3'd0);
        send_token(OP_END, 8'd0, 3'd0);
        send_token(OP_OPERAND, 8'd1, 3'd0);
        send_token(OP_OPERATOR, 8'd10, 3'd2);
        send_token(OP_OPERAND, 8'd2, 3'd0);
        send_token(OP_RPAREN, 8'd41, 3'd0);
        send_token(OP_END, 8'd0, 3'd0);
        send_token(OP_LPAREN, 8'd40, 3'd5);
        send_token(OP_OPERAND, 8'd3, 3'd0);
        send_token(OP_END, 8'd0, 3'd0);
        send_token(OP_RPAREN, 8'd41, 3'd0);
        send_token(OP_LPAREN, 8'd40, 3'd0);
        send_token(OP_END, 8'd0, 3'd0);
        send_token(OP_END, 8'd0, 3'd0);
    endtask

    task automatic test_ignored_categories();
        send_token(OP_LPAREN, 8'd40, 3'd0);
        send_token(OP_RSVD5, 8'd255, 3'd7);
        send_token(OP_OPERAND, 8'd1, 3'd0);
        send_token(OP_RSVD6, 8'd0, 3'd0);
        send_token(OP_RPAREN, 8'd41, 3'd0);
        send_token(OP_RSVD7, 8'd170, 3'd5);
        send_token(OP_END, 8'd0, 3'd0);
    endtask

    // Fill the stack with paren groups of rising operators, then overflow it
    task automatic test_stack_overflow();
        for (int g = 0; g < STACK_DEPTH / 8; g++) begin
            send_token(OP_LPAREN, 8'd40, 3'd0);
            for (int p = 1; p < 8; p++) begin
                send_token(OP_OPERATOR, 8'(16 * g + p), 3'(p));
            end
        end
        send_token(OP_LPAREN, 8'd99, 3'd0);
        send_token(OP_OPERATOR, 8'd200, 3'd7);
        for (int g = 0; g < STACK_DEPTH / 8; g++) begin
            send_token(OP_RPAREN, 8'd41, 3'd0);
        end
        send_token(OP_END, 8'd0, 3'd0);
    endtask

    // Hold the receiver off while the sender keeps offering requests
    task automatic test_output_backpressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            begin
                for (int k = 0; k < 30; k++) begin
                    send_random(OP_OPERAND);
                    send_random(OP_OPERATOR);
                end
                send_random(OP_OPERAND);
                send_random(OP_END);
                i_in_valid <= 1'b0;
            end
        join
        wait_results_done();
    endtask

    // Mostly well-formed expressions with random content, some broken, some noise
    task automatic test_random_expressions();
        int target;
        int mode;
        int terms;
        int open_parens;
        target = tokens_accepted + RANDOM_ITEMS;
        while (tokens_accepted < target) begin
            // run a stretch without idling at the start and in the middle
            no_idle = (tokens_accepted < target - RANDOM_ITEMS + 50) ||
                      (tokens_accepted > target - 60 && tokens_accepted < target - 30);
            mode = $urandom_range(0, 9);
            if (mode == 9) begin
                repeat ($urandom_range(1, 6)) send_random(3'($urandom_range(0, 7)));
            end else begin
                open_parens = 0;
                terms = $urandom_range(1, 8);
                for (int t = 0; t < terms; t++) begin
                    if (t > 0) begin
                        send_random(OP_OPERATOR);
                    end
                    while ($urandom_range(0, 3) == 0 && open_parens < 12) begin
                        send_random(OP_LPAREN);
                        open_parens++;
                    end
                    send_random(OP_OPERAND);
                    while (open_parens > 0 && $urandom_range(0, 2) == 0) begin
                        send_random(OP_RPAREN);
                        open_parens--;
                    end
                end
                if (mode == 8) begin
                    send_random(OP_RPAREN);
                end
                if (mode != 7) begin
                    while (open_parens > 0) begin
                        send_random(OP_RPAREN);
                        open_parens--;
                    end
                end
                send_random(OP_END);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_operands_and_end();
        test_precedence_order();
        test_paren_matching();
        test_paren_errors();
        test_ignored_categories();
        test_stack_overflow();
        test_output_backpressure();
        test_random_expressions();
        i_in_valid <= 1'b0;
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> infix_to_postfix_converter_core.f
+incdir+src
src/i2p_pkg.sv
src/i2p_cell.sv
src/infix_to_postfix_converter_core.sv
tb/tb.sv
